@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file gn2d_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked every clock outside reset
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hw/rtl/gn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants, types and helpers for the 2-D gradient noise sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package gn2d_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_SEED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_SCALE = 1'd1;

   localparam logic [31:0] MUL_A = 32'd374761393;
   localparam logic [31:0] MUL_B = 32'd668265263;
   localparam logic [31:0] MUL_C = 32'd1274126177;

   localparam logic [31:0] SCALE_RESET = 32'd65536;

   typedef logic [2:0] grad_sel_type;

   // first half of the avalanche: xor-shift; multiply happens in a stage
   function automatic logic [31:0] xs13(input logic [31:0] h);
      return h ^ (h >> 13);
   endfunction

   function automatic logic [31:0] xs16(input logic [31:0] h);
      return h ^ (h >> 16);
   endfunction

   // gradient dot product, offsets are signed 18-bit
   function automatic logic signed [18:0] corner_dot(
      input grad_sel_type g, input logic signed [17:0] dx, input logic signed [17:0] dy);
      logic signed [18:0] x;
      logic signed [18:0] y;
      x = 19'(dx);
      y = 19'(dy);
      case (g)
         3'd0:    return x + y;
         3'd1:    return y - x;
         3'd2:    return x - y;
         3'd3:    return -x - y;
         3'd4:    return x;
         3'd5:    return -x;
         3'd6:    return y;
         default: return -y;
      endcase
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gradient_noise_2d_sample.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_sample
// 2-D gradient noise sampler with quintic fade, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample beat (point, tag, chunk coordinate); it is taken
//   at a clock edge with req_valid high and req_stall low. rsp_* returns one
//   noise_value beat per request, in order, taken with rsp_valid high and
//   rsp_stall low. csr_* writes world_seed (index 0) or coordinate_scale
//   (index 1); write them only while the pipe is empty.
//   Throughput: one beat per cycle while rsp_stall is low. The pipe depth
//   is set by the chained hash multiplies (chunk hash, then two corner
//   avalanches) plus the blend. A stall on rsp_stall freezes the whole
//   pipe; req_stall follows it combinationally, so no beat is lost or
//   repeated.
//   Reset (synchronous, active high) clears all valid bits and returns the
//   registers to seed 0 and scale 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module gradient_noise_2d_sample #(
   parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write,
   input  wire  [gn2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gn2d_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [31:0]                   req_point_x,
   input  wire  signed [31:0]                   req_point_y,
   input  wire  [7:0]                           req_feature_tag,
   input  wire  signed [31:0]                   req_chunk_x,
   input  wire  signed [31:0]                   req_chunk_y,
   input  wire  signed [31:0]                   req_chunk_z,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [15:0]                          rsp_noise_value
);
   import gn2d_pkg::*;

   localparam int NST = 16;
   localparam int SH  = 2 * FRAC_BITS;

   logic [63:0] seed_ff;
   logic [31:0] scale_ff;
   logic [31:0] seed_fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WORLD_SEED:  seed_ff  <= csr_data;
            CSR_COORD_SCALE: scale_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end
   assign seed_fold = seed_ff[63:32] ^ seed_ff[31:0];

   // pipe advance
   logic adv;
   logic [NST-1:0] v_ff;
   assign adv       = !rsp_stall;
   assign req_stall = rsp_stall;
   assign rsp_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NST-2:0], req_valid};
   end

   // ---------------- stage 1: scale multiply, chunk multiplies
   logic signed [64:0] px1_ff, py1_ff;
   logic [31:0] ca1_ff, cb1_ff, cc1_ff;
   logic [7:0]  tag1_ff;
   // ---------------- stage 2: split, chunk xor/xs13
   logic [31:0] x0_2_ff, y0_2_ff;
   logic [15:0] tx2_ff, ty2_ff;
   logic [31:0] ch2_ff;
   logic [7:0]  tag2_ff;
   // stage 3: chunk *C
   logic [31:0] x0_3_ff, y0_3_ff, ch3_ff;
   logic [15:0] tx3_ff, ty3_ff;
   logic [7:0]  tag3_ff;
   // stage 4: seed, corner coordinate products
   logic [31:0] seed4_ff, xa0_4_ff, xa1_4_ff, yb0_4_ff, yb1_4_ff;
   logic [15:0] tx4_ff, ty4_ff;
   // corner hash stages 5..10 (4 lanes)
   logic [31:0] h5_ff [4];
   logic [31:0] h6_ff [4];
   logic [31:0] h7_ff [4];
   logic [31:0] h8_ff [4];
   logic [31:0] h9_ff [4];
   logic [2:0]  g10_ff [4];
   // fraction carry lines to stage 10
   logic [15:0] tx_d_ff [6];
   logic [15:0] ty_d_ff [6];
   // fade pipe, runs in parallel from stage 5
   logic [31:0] sq_x5_ff, sq_y5_ff;
   logic [15:0] cx6_ff, cy6_ff;
   // polynomial reaches 10.0 at t = 0, needs 20 bits
   logic [19:0] px6_ff, py6_ff;
   logic [15:0] fx7_ff, fy7_ff;
   logic [15:0] fx_d_ff [3];
   logic [15:0] fy_d_ff [3];
   // stage 11: dot products
   logic signed [18:0] d11_ff [4];
   logic [15:0] fx11_ff, fy11_ff;
   // stage 12: x-blend products, 13: x-blend result
   logic signed [36:0] pb12_ff, pt12_ff;
   logic signed [18:0] b12_ff, t12_ff;
   logic [15:0] fy12_ff;
   logic signed [19:0] bot13_ff, top13_ff;
   logic [15:0] fy13_ff;
   logic signed [37:0] p14_ff;
   logic signed [19:0] bot14_ff;
   logic [15:0] n15_ff;

   // stage 1 comb
   logic signed [64:0] sc_s;
   assign sc_s = $signed({33'd0, scale_ff});

   // stage 2 comb: split
   logic [31:0] x0_c, y0_c;
   logic [15:0] tx_c, ty_c;
   logic signed [64:0] xsh, ysh;
   assign xsh  = px1_ff >>> SH;
   assign ysh  = py1_ff >>> SH;
   assign x0_c = xsh[31:0];
   assign y0_c = ysh[31:0];
   assign tx_c = px1_ff[SH-1 -: 16];
   assign ty_c = py1_ff[SH-1 -: 16];

   // fade comb pieces
   logic [47:0] cubx, cuby;
   logic [39:0] polx, poly;
   assign cubx = 48'(sq_x5_ff) * 48'(tx_d_ff[0]);
   assign cuby = 48'(sq_y5_ff) * 48'(ty_d_ff[0]);
   assign polx = 40'(6) * 40'(sq_x5_ff) + (40'd10 << 32) - 40'(15) * (40'(tx_d_ff[0]) << 16);
   assign poly = 40'(6) * 40'(sq_y5_ff) + (40'd10 << 32) - 40'(15) * (40'(ty_d_ff[0]) << 16);

   logic [34:0] fpx, fpy;
   assign fpx = 35'(cx6_ff) * 35'(px6_ff);
   assign fpy = 35'(cy6_ff) * 35'(py6_ff);

   // dot products
   logic signed [17:0] ox0, ox1, oy0, oy1;
   assign ox0 = $signed({2'b00, tx_d_ff[5]});
   assign oy0 = $signed({2'b00, ty_d_ff[5]});
   assign ox1 = ox0 - 18'sd65536;
   assign oy1 = oy0 - 18'sd65536;

   // final blend and offset
   logic signed [20:0] v_c;
   assign v_c   = 21'(bot14_ff) + 21'(p14_ff >>> 16) + 21'sd65536;

   always_ff @(posedge clock) begin
      if (adv) begin
         // 1
         px1_ff  <= 65'($signed(req_point_x)) * sc_s;
         py1_ff  <= 65'($signed(req_point_y)) * sc_s;
         ca1_ff  <= req_chunk_x * MUL_A;
         cb1_ff  <= req_chunk_y * MUL_B;
         cc1_ff  <= req_chunk_z * MUL_C;
         tag1_ff <= req_feature_tag;
         // 2
         x0_2_ff <= x0_c;  y0_2_ff <= y0_c;
         tx2_ff  <= tx_c;  ty2_ff  <= ty_c;
         ch2_ff  <= xs13(ca1_ff ^ cb1_ff ^ cc1_ff);
         tag2_ff <= tag1_ff;
         // 3
         x0_3_ff <= x0_2_ff; y0_3_ff <= y0_2_ff;
         tx3_ff  <= tx2_ff;  ty3_ff  <= ty2_ff;
         ch3_ff  <= ch2_ff * MUL_C;
         tag3_ff <= tag2_ff;
         // 4
         seed4_ff <= seed_fold ^ xs16(ch3_ff) ^ {24'd0, tag3_ff};
         xa0_4_ff <= x0_3_ff * MUL_A;
         xa1_4_ff <= (x0_3_ff + 32'd1) * MUL_A;
         yb0_4_ff <= y0_3_ff * MUL_B;
         yb1_4_ff <= (y0_3_ff + 32'd1) * MUL_B;
         tx4_ff   <= tx3_ff; ty4_ff <= ty3_ff;
         // 5: lanes 00,10,01,11
         h5_ff[0] <= xs13(seed4_ff ^ xa0_4_ff ^ yb0_4_ff);
         h5_ff[1] <= xs13(seed4_ff ^ xa1_4_ff ^ yb0_4_ff);
         h5_ff[2] <= xs13(seed4_ff ^ xa0_4_ff ^ yb1_4_ff);
         h5_ff[3] <= xs13(seed4_ff ^ xa1_4_ff ^ yb1_4_ff);
         for (int i = 0; i < 4; i++) begin
            h6_ff[i]  <= h5_ff[i] * MUL_C;
            h7_ff[i]  <= xs13(xs16(h6_ff[i]));
            h8_ff[i]  <= h7_ff[i] * MUL_C;
            h9_ff[i]  <= xs16(h8_ff[i]);
            g10_ff[i] <= h9_ff[i][2:0];
         end
         tx_d_ff[0] <= tx4_ff; ty_d_ff[0] <= ty4_ff;
         for (int i = 1; i < 6; i++) begin
            tx_d_ff[i] <= tx_d_ff[i-1];
            ty_d_ff[i] <= ty_d_ff[i-1];
         end
         // fade
         sq_x5_ff <= 32'(tx4_ff) * 32'(tx4_ff);
         sq_y5_ff <= 32'(ty4_ff) * 32'(ty4_ff);
         cx6_ff   <= cubx[47:32];
         cy6_ff   <= cuby[47:32];
         px6_ff   <= polx[35:16];
         py6_ff   <= poly[35:16];
         fx7_ff   <= fpx[31:16];
         fy7_ff   <= fpy[31:16];
         fx_d_ff[0] <= fx7_ff; fy_d_ff[0] <= fy7_ff;
         for (int i = 1; i < 3; i++) begin
            fx_d_ff[i] <= fx_d_ff[i-1];
            fy_d_ff[i] <= fy_d_ff[i-1];
         end
         // 11
         d11_ff[0] <= corner_dot(g10_ff[0], ox0, oy0);
         d11_ff[1] <= corner_dot(g10_ff[2], ox0, oy1);
         d11_ff[2] <= corner_dot(g10_ff[1], ox1, oy0);
         d11_ff[3] <= corner_dot(g10_ff[3], ox1, oy1);
         fx11_ff   <= fx_d_ff[2];
         fy11_ff   <= fy_d_ff[2];
         // 12: f*(b-a); d[0]=g00 d[2]=g10 ; d[1]=g01 d[3]=g11
         pb12_ff <= $signed({1'b0, fx11_ff}) * (37'(d11_ff[2]) - 37'(d11_ff[0]));
         pt12_ff <= $signed({1'b0, fx11_ff}) * (37'(d11_ff[3]) - 37'(d11_ff[1]));
         b12_ff  <= d11_ff[0];
         t12_ff  <= d11_ff[1];
         fy12_ff <= fy11_ff;
         // 13
         bot13_ff <= 20'(b12_ff) + 20'(pb12_ff >>> 16);
         top13_ff <= 20'(t12_ff) + 20'(pt12_ff >>> 16);
         fy13_ff  <= fy12_ff;
         // 14
         p14_ff   <= $signed({1'b0, fy13_ff}) * 38'(top13_ff - bot13_ff);
         bot14_ff <= bot13_ff;
         // 15: map and saturate
         if (v_c < 0)                n15_ff <= 16'd0;
         else if (v_c[20:1] > 20'sd65535) n15_ff <= 16'hFFFF;
         else                        n15_ff <= v_c[16:1];
         rsp_noise_value <= n15_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/gn2d_checker.sv @@
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks on the noise sampler's channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gn2d_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [15:0] rsp_noise_value
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_noise_value), "stalled rsp beat changed")
   `CHK_IMPLY(a_stall_follow, clock, reset, 1'b1, req_stall == rsp_stall, "req stall differs from rsp stall")
   `CHK_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")
endmodule

bind gradient_noise_2d_sample gn2d_checker u_gn2d_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value)
);
`default_nettype wire
